FILE: rtl/fcar_pkg.sv
// Shared constants and types for the framed command ADC reporter.
package fcar_pkg;

  localparam int unsigned CMD_CAPACITY = 32;
  localparam int unsigned LEN_W        = $clog2(CMD_CAPACITY + 1);
  localparam int unsigned KEEP_CHARS   = 3;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned SAMPLE_W = 12;
  localparam int unsigned PERIOD_W = 16;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(300);

  localparam logic [BYTE_W-1:0] CH_START = 8'h21; // '!'
  localparam logic [BYTE_W-1:0] CH_END   = 8'h23; // '#'
  localparam logic [BYTE_W-1:0] CH_R     = 8'h52;
  localparam logic [BYTE_W-1:0] CH_S     = 8'h53;
  localparam logic [BYTE_W-1:0] CH_T     = 8'h54;
  localparam logic [BYTE_W-1:0] CH_O     = 8'h4F;
  localparam logic [BYTE_W-1:0] CH_K     = 8'h4B;

  // Item kind codes
  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_TICK = 1'b1;

  // Report kind codes
  localparam logic REPORT_FIRST  = 1'b0;
  localparam logic REPORT_REPEAT = 1'b1;

  // Outcome of one byte, valid in the cycle the byte is taken
  typedef struct packed {
    logic done;    // end mark closed a command
    logic is_rst;  // command was exactly RST
    logic is_ok;   // command starts with OK
  } cmd_match_t;

endpackage

FILE: rtl/fcar_if.sv
// Valid/ready channel interfaces for command items and reports.
interface fcar_item_if;
  logic                              valid;
  logic                              ready;
  logic                              kind;
  logic [fcar_pkg::BYTE_W-1:0]       rx_byte;
  logic [fcar_pkg::SAMPLE_W-1:0]     conv_sample;

  modport source (output valid, output kind, output rx_byte, output conv_sample, input ready);
  modport sink   (input valid, input kind, input rx_byte, input conv_sample, output ready);
endinterface

interface fcar_report_if;
  logic                              valid;
  logic                              ready;
  logic [fcar_pkg::SAMPLE_W-1:0]     report_value;
  logic                              repeat_res;

  modport source (output valid, output report_value, output repeat_res, input ready);
  modport sink   (input valid, input report_value, input repeat_res, output ready);
endinterface

FILE: rtl/fcar_cmd_parser.sv
// Frame parser: collects bytes between start and end marks and matches commands.
module fcar_cmd_parser (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          byte_take,
  input  logic [fcar_pkg::BYTE_W-1:0]   rx_byte,
  output fcar_pkg::cmd_match_t          match
);

  logic                                 reading;
  logic [fcar_pkg::BYTE_W-1:0]          cmd_chars [fcar_pkg::KEEP_CHARS];
  logic [fcar_pkg::LEN_W-1:0]           cmd_length;

  localparam logic [fcar_pkg::LEN_W-1:0] LEN_FULL = fcar_pkg::LEN_W'(fcar_pkg::CMD_CAPACITY);
  localparam logic [fcar_pkg::LEN_W-1:0] LEN_KEEP = fcar_pkg::LEN_W'(fcar_pkg::KEEP_CHARS);
  localparam logic [fcar_pkg::LEN_W-1:0] LEN_TWO  = fcar_pkg::LEN_W'(2);

  logic is_start;
  logic is_end;

  assign is_start = (rx_byte == fcar_pkg::CH_START);
  assign is_end   = (rx_byte == fcar_pkg::CH_END);

  always_comb begin
    match.done   = byte_take && reading && is_end;
    match.is_rst = (cmd_length == LEN_KEEP) && (fcar_pkg::KEEP_CHARS < fcar_pkg::CMD_CAPACITY)
                   && (cmd_chars[0] == fcar_pkg::CH_R) && (cmd_chars[1] == fcar_pkg::CH_S)
                   && (cmd_chars[2] == fcar_pkg::CH_T);
    match.is_ok  = (cmd_length >= LEN_TWO) && (cmd_chars[0] == fcar_pkg::CH_O)
                   && (cmd_chars[1] == fcar_pkg::CH_K);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      reading    <= 1'b0;
      cmd_length <= '0;
      for (int i = 0; i < fcar_pkg::KEEP_CHARS; i++) begin
        cmd_chars[i] <= '0;
      end
    end else if (byte_take) begin
      if (!reading) begin
        if (is_start) begin
          reading    <= 1'b1;
          cmd_length <= '0;
          for (int i = 0; i < fcar_pkg::KEEP_CHARS; i++) begin
            cmd_chars[i] <= '0;
          end
        end
      end else if (is_end) begin
        reading    <= 1'b0;
        cmd_length <= '0;
        for (int i = 0; i < fcar_pkg::KEEP_CHARS; i++) begin
          cmd_chars[i] <= '0;
        end
      end else if (!is_start && (cmd_length < LEN_FULL)) begin
        // only the leading characters are stored; the rest are counted
        for (int i = 0; i < fcar_pkg::KEEP_CHARS; i++) begin
          if (cmd_length == fcar_pkg::LEN_W'(i)) begin
            cmd_chars[i] <= rx_byte;
          end
        end
        cmd_length <= cmd_length + fcar_pkg::LEN_W'(1);
      end
    end
  end

endmodule

FILE: rtl/framed_command_adc_reporter.sv
// Top level: framed command ADC reporter with periodic report timer.
//
// Input channel "item" carries either a received byte (kind 0) or one timer
// tick (kind 1), plus the current converter sample. Bytes between '!' and '#'
// form a command. On an exact RST, while not reporting, the sample is held
// and a first report goes out; a command starting with OK stops reporting.
// While reporting, one repeat report goes out every report_period ticks
// (a period of zero acts as one).
// Output channel "report" carries the held sample and a repeat flag.
// cfg_wr_en/cfg_wr_data write report_period; write only while idle.
// A report is registered and is valid in the cycle after the item that causes it.
// Throughput: one item per cycle while no report waits on a low report.ready;
// all state updates in the accept cycle. The result sits in one output register:
// while it waits and report.ready is low, item.ready is low too, so nothing is lost or dropped.
// Reset (rst, synchronous) returns to idle framing, stops reporting, clears
// the held sample and countdown, and sets report_period to 300.
module framed_command_adc_reporter (
  input  logic                            clk,
  input  logic                            rst,
  fcar_item_if.sink                       item,
  fcar_report_if.source                   report,
  input  logic                            cfg_wr_en,
  input  logic [fcar_pkg::PERIOD_W-1:0]   cfg_wr_data
);

  logic [fcar_pkg::PERIOD_W-1:0]  report_period;
  logic                           reporting;
  logic [fcar_pkg::SAMPLE_W-1:0]  held_sample;
  logic [fcar_pkg::PERIOD_W-1:0]  countdown;
  logic                           out_valid;
  logic [fcar_pkg::SAMPLE_W-1:0]  out_value;
  logic                           out_repeat;

  logic                           take;
  logic                           byte_take;
  logic                           tick_take;
  fcar_pkg::cmd_match_t           match;
  logic [fcar_pkg::PERIOD_W-1:0]  period_eff;
  logic                           start_report;
  logic                           tick_report;

  assign item.ready = !out_valid || report.ready;
  assign take       = item.valid && item.ready;
  assign byte_take  = take && (item.kind == fcar_pkg::KIND_BYTE);
  assign tick_take  = take && (item.kind == fcar_pkg::KIND_TICK);

  assign report.valid        = out_valid;
  assign report.report_value = out_value;
  assign report.repeat_res   = out_repeat;

  fcar_cmd_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .byte_take (byte_take),
    .rx_byte   (item.rx_byte),
    .match     (match)
  );

  assign period_eff   = (report_period == '0) ? fcar_pkg::PERIOD_W'(1) : report_period;
  assign start_report = match.done && match.is_rst && !reporting;
  assign tick_report  = tick_take && reporting && (countdown <= fcar_pkg::PERIOD_W'(1));

  always_ff @(posedge clk) begin
    if (rst) begin
      report_period <= fcar_pkg::PERIOD_RESET;
      reporting     <= 1'b0;
      held_sample   <= '0;
      countdown     <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        report_period <= cfg_wr_data;
      end

      if (tick_take && reporting) begin
        if (tick_report) begin
          countdown <= period_eff;
        end else begin
          countdown <= countdown - fcar_pkg::PERIOD_W'(1);
        end
      end

      if (start_report) begin
        held_sample <= item.conv_sample;
        reporting   <= 1'b1;
        countdown   <= period_eff;
      end
      if (match.done && match.is_ok) begin
        reporting <= 1'b0;
      end

      if (start_report || tick_report) begin
        out_valid <= 1'b1;
      end else if (report.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload register, loaded only on a new report
  always_ff @(posedge clk) begin
    if (start_report) begin
      out_value  <= item.conv_sample;
      out_repeat <= fcar_pkg::REPORT_FIRST;
    end else if (tick_report) begin
      out_value  <= held_sample;
      out_repeat <= fcar_pkg::REPORT_REPEAT;
    end
  end

endmodule
